// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/fdep_pkg.sv =====
`timescale 1ns / 1ps

package fdep_pkg;

  // one raw byte of a directory cluster
  typedef struct packed {
    logic [7:0] data_byte;
    logic       cluster_start;
  } in_t;

  // one parsed short-name directory entry
  typedef struct packed {
    logic [63:0] name_base;
    logic [23:0] name_extension;
    logic [7:0]  attribute_bits;
    logic [31:0] start_cluster;
    logic [31:0] byte_size;
  } out_t;

  // capture stage result toward the output register
  typedef struct packed {
    logic emit;
    out_t entry;
  } cap_res_t;

  localparam int unsigned POS_W = 5;

  localparam logic [POS_W-1:0] NAME_BASE_END     = 5'd8;
  localparam logic [POS_W-1:0] NAME_EXT_END      = 5'd11;
  localparam logic [POS_W-1:0] ATTR_OFFSET       = 5'd11;
  localparam logic [POS_W-1:0] CLUSTER_HI_OFFSET = 5'd20;
  localparam logic [POS_W-1:0] CLUSTER_LO_OFFSET = 5'd26;
  localparam logic [POS_W-1:0] SIZE_OFFSET       = 5'd28;
  localparam logic [POS_W-1:0] ENTRY_LAST_BYTE   = 5'd31;

  localparam logic [7:0] LONG_NAME_ATTR = 8'h0F;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;

endpackage

// ===== hw/rtl/fat_directory_entry_parser.sv =====
`timescale 1ns / 1ps

// Directory entry parser: takes the bytes of a directory cluster, one byte beat
// per cycle, cuts them into 32-byte entries and gives one entry beat for each
// short-name entry (long-name entries with attribute 0x0F and entries whose
// first name byte is zero or a space give nothing). cluster_start on a byte
// makes it byte 0 of a new entry; a partial entry is then dropped. The block
// sustains one byte per cycle: an accepted byte is held in an input register,
// goes through the field capture logic in the next cycle and its entry, if
// any, is loaded into the output register when the byte steps on, so an entry
// passes the input register and then the output register. Only a byte that
// completes an entry waits, and only while the output register still holds an
// entry not yet taken; with entries at most one per 32 bytes a slow consumer
// rarely stalls the byte stream.
module fat_directory_entry_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  fdep_pkg::in_t  byte_data,
  output logic           entry_valid,
  input  logic           entry_ready,
  output fdep_pkg::out_t entry_data
);
  import fdep_pkg::*;

  // input register
  logic     held_valid;
  in_t      held_item;

  logic     step;
  logic     out_free;
  cap_res_t res;

  // the held byte moves on unless it completes an entry and the output is full
  assign step       = held_valid && (!res.emit || out_free);
  assign byte_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      held_item <= byte_data;
    end
  end

  // position counter and field captures
  fdep_capture u_capture (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held_item),
    .res  (res)
  );

  // result register toward the consumer
  fdep_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && res.emit),
    .entry       (res.entry),
    .free        (out_free),
    .entry_valid (entry_valid),
    .entry_ready (entry_ready),
    .entry_data  (entry_data)
  );

endmodule

// ===== hw/rtl/fdep_capture.sv =====
`timescale 1ns / 1ps

module fdep_capture (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  fdep_pkg::in_t    item,
  output fdep_pkg::cap_res_t res
);
  import fdep_pkg::*;

  logic [POS_W-1:0] entry_position;
  logic [63:0]      base_name_reg;
  logic [23:0]      extension_reg;
  logic [7:0]       attribute_reg;
  logic [15:0]      cluster_high_reg;
  logic [15:0]      cluster_low_reg;
  logic [31:0]      size_reg;

  logic [POS_W-1:0] pos;
  logic [7:0]       name_b;
  logic [63:0]      base_name_next;
  logic [23:0]      extension_next;
  logic [7:0]       attribute_next;
  logic [15:0]      cluster_high_next;
  logic [15:0]      cluster_low_next;
  logic [31:0]      size_next;

  assign pos    = item.cluster_start ? '0 : entry_position;
  assign name_b = (item.data_byte == 8'h00) ? SPACE_CHAR : item.data_byte;

  always_comb begin
    base_name_next    = base_name_reg;
    extension_next    = extension_reg;
    attribute_next    = attribute_reg;
    cluster_high_next = cluster_high_reg;
    cluster_low_next  = cluster_low_reg;
    size_next         = size_reg;
    if (pos < NAME_BASE_END) begin
      base_name_next = {base_name_reg[55:0], name_b};
    end else if (pos < NAME_EXT_END) begin
      extension_next = {extension_reg[15:0], name_b};
    end else if (pos == ATTR_OFFSET) begin
      attribute_next = item.data_byte;
    end else if (pos == CLUSTER_HI_OFFSET) begin
      cluster_high_next[7:0] = item.data_byte;
    end else if (pos == CLUSTER_HI_OFFSET + 5'd1) begin
      cluster_high_next[15:8] = item.data_byte;
    end else if (pos == CLUSTER_LO_OFFSET) begin
      cluster_low_next[7:0] = item.data_byte;
    end else if (pos == CLUSTER_LO_OFFSET + 5'd1) begin
      cluster_low_next[15:8] = item.data_byte;
    end else if (pos >= SIZE_OFFSET) begin
      case (pos[1:0])
        2'd0:    size_next[7:0]   = item.data_byte;
        2'd1:    size_next[15:8]  = item.data_byte;
        2'd2:    size_next[23:16] = item.data_byte;
        2'd3:    size_next[31:24] = item.data_byte;
        default: size_next        = size_reg;
      endcase
    end
  end

  // the last size byte lands in the same step that emits the entry
  always_comb begin
    res.emit = (pos == ENTRY_LAST_BYTE) && (attribute_reg != LONG_NAME_ATTR) &&
               (base_name_reg[63:56] != SPACE_CHAR);
    res.entry.name_base      = base_name_reg;
    res.entry.name_extension = extension_reg;
    res.entry.attribute_bits = attribute_reg;
    res.entry.start_cluster  = {cluster_high_reg, cluster_low_reg};
    res.entry.byte_size      = size_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position   <= '0;
      base_name_reg    <= '0;
      extension_reg    <= '0;
      attribute_reg    <= '0;
      cluster_high_reg <= '0;
      cluster_low_reg  <= '0;
      size_reg         <= '0;
    end else if (step) begin
      entry_position   <= pos + 5'd1;
      base_name_reg    <= base_name_next;
      extension_reg    <= extension_next;
      attribute_reg    <= attribute_next;
      cluster_high_reg <= cluster_high_next;
      cluster_low_reg  <= cluster_low_next;
      size_reg         <= size_next;
    end
  end

endmodule

// ===== hw/rtl/fdep_out_reg.sv =====
`timescale 1ns / 1ps

module fdep_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  fdep_pkg::out_t entry,
  output logic           free,
  output logic           entry_valid,
  input  logic           entry_ready,
  output fdep_pkg::out_t entry_data
);
  import fdep_pkg::*;

  logic valid;
  out_t data;

  assign free        = !valid || entry_ready;
  assign entry_valid = valid;
  assign entry_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (entry_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= entry;
    end
  end

endmodule

// ===== hw/rtl/fdep_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdep_checker (
  input logic           clk,
  input logic           rst,
  input logic           entry_valid,
  input logic           entry_ready,
  input fdep_pkg::out_t entry_data
);
  import fdep_pkg::*;

  logic [7:0]  first_char;
  logic [23:0] ext_bytes;
  logic        ext_has_zero;

  assign first_char   = entry_data.name_base[63:56];
  assign ext_bytes    = entry_data.name_extension;
  assign ext_has_zero = (ext_bytes[23:16] == 8'h00) || (ext_bytes[15:8] == 8'h00) ||
                        (ext_bytes[7:0] == 8'h00);

  // a stalled entry beat stays and holds its payload
  `ASSERT_NEXT(a_entry_hold, clk, rst, entry_valid && !entry_ready, entry_valid)
  `ASSERT_NEXT(a_entry_stable, clk, rst, entry_valid && !entry_ready, $stable(entry_data))

  // long-name entries are never given
  `ASSERT_IMPLY(a_no_long_name, clk, rst, entry_valid, entry_data.attribute_bits != LONG_NAME_ATTR)

  // blank or empty names are never given
  `ASSERT_IMPLY(a_name_first, clk, rst, entry_valid, first_char != SPACE_CHAR && first_char != 8'h00)

  // zero bytes in the extension come out as spaces
  `ASSERT_IMPLY(a_ext_no_zero, clk, rst, entry_valid, !ext_has_zero)

endmodule

bind fat_directory_entry_parser fdep_checker u_checker (.*);
